// File: sv/fsc_pkg.sv
// Shared types, constants and reset tables for the flow size class counter.
// No dependencies; imported by every module of the block.
package fsc_pkg;

  localparam int NUM_CLASSES_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int OP_W    = 2;
  localparam int SIZE_W  = 31;
  localparam int IDX_W   = 4;
  localparam int TAG_W   = 8;
  localparam int COUNT_W = 32;
  localparam int ACT_W   = 5;

  localparam logic [ACT_W-1:0]   ACT_RESET = ACT_W'(3);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [SIZE_W-1:0] RESET_BOUND0 = SIZE_W'(113154);
  localparam logic [SIZE_W-1:0] RESET_BOUND1 = SIZE_W'(5671937);
  localparam logic [SIZE_W-1:0] RESET_BOUND2 = SIZE_W'(1000000000);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_READ     = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic {
    BS_CLASS = 1'b0,
    BS_APPLY = 1'b1
  } bstate_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] flow_size;
    logic [IDX_W-1:0]  entry_index;
    logic [TAG_W-1:0]  class_tag;
    logic [SIZE_W-1:0] upper_bound;
    logic              load_ok;
  } item_t;

  function automatic logic [SIZE_W-1:0] reset_bound(input int i);
    logic [SIZE_W-1:0] b;
    case (i)
      0:       b = RESET_BOUND0;
      1:       b = RESET_BOUND1;
      2:       b = RESET_BOUND2;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [TAG_W-1:0] reset_id(input int i);
    logic [TAG_W-1:0] t;
    if (i < 3) begin
      t = TAG_W'(i);
    end else begin
      t = '0;
    end
    return t;
  endfunction

endpackage

// File: sv/fsc_front.sv
// Front end: decodes an incoming transaction into a queue entry.
// Depends on fsc_pkg.
module fsc_front import fsc_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [SIZE_W-1:0] in_flow_size,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [TAG_W-1:0]  in_class_tag,
  input  logic [SIZE_W-1:0] in_upper_bound,
  output logic              push_valid,
  input  logic              push_ready,
  output item_t             push_item
);

  always_comb begin
    push_item.op          = op_t'(in_op);
    push_item.flow_size   = in_flow_size;
    push_item.entry_index = in_entry_index;
    push_item.class_tag   = in_class_tag;
    push_item.upper_bound = in_upper_bound;
    push_item.load_ok     = (int'(in_entry_index) < NUM_CLASSES);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// File: sv/fsc_queue.sv
// Short FIFO of decoded transactions between front end and back end.
// Depends on fsc_pkg.
module fsc_queue import fsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  head_valid,
  input  logic  pop,
  output item_t head_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t           mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rptr_r];
  assign push       = push_valid && push_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

// File: sv/fsc_back.sv
// Back end: class table, bound search, counter update and output register.
// Depends on fsc_pkg; fed by fsc_queue.
module fsc_back import fsc_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ACT_W-1:0]   active_classes,
  input  logic               head_valid,
  input  item_t              head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_matched,
  output logic [TAG_W-1:0]   out_class_out,
  output logic [COUNT_W-1:0] out_count_out
);

  localparam int IW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [TAG_W-1:0]   id_r    [NUM_CLASSES];
  logic [SIZE_W-1:0]  bound_r [NUM_CLASSES];
  logic [COUNT_W-1:0] cnt_r   [NUM_CLASSES];

  bstate_t            state_r, state_nxt;
  item_t              it_r;
  logic               found_r;
  logic [TAG_W-1:0]   cls_r;
  logic               read_ok_r;

  logic               out_valid_r;
  logic               out_matched_r;
  logic [TAG_W-1:0]   out_class_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [ACT_W-1:0]   act_eff;
  logic [NUM_CLASSES-1:0] lane_act;
  logic               hit_any;
  logic [TAG_W-1:0]   hit_id;
  logic               found_c;
  logic [TAG_W-1:0]   cls_c;
  logic               read_ok_c;
  logic               cnt_any;
  logic [IW-1:0]      cnt_idx;
  logic [IW-1:0]      idx_w;
  logic [COUNT_W-1:0] cnt_inc;
  logic               out_free;
  logic               apply;

  always_comb begin
    if (int'(active_classes) > NUM_CLASSES) begin
      act_eff = ACT_W'(NUM_CLASSES);
    end else begin
      act_eff = active_classes;
    end
    for (int i = 0; i < NUM_CLASSES; i++) begin
      lane_act[i] = (i < int'(act_eff));
    end
  end

  // bound search on the queue head
  always_comb begin
    hit_any = 1'b0;
    hit_id  = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (!hit_any && lane_act[i] && (head_item.flow_size <= bound_r[i])) begin
        hit_any = 1'b1;
        hit_id  = id_r[i];
      end
    end
    if (act_eff == ACT_W'(1)) begin
      found_c = 1'b1;
      cls_c   = '0;
    end else begin
      found_c = hit_any;
      cls_c   = hit_id;
    end
    read_ok_c = (int'(head_item.entry_index) < int'(act_eff));
  end

  // first active entry holding the class id
  always_comb begin
    cnt_any = 1'b0;
    cnt_idx = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (!cnt_any && lane_act[i] && (id_r[i] == cls_r)) begin
        cnt_any = 1'b1;
        cnt_idx = IW'(i);
      end
    end
    cnt_inc = (cnt_r[cnt_idx] == COUNT_MAX) ? cnt_r[cnt_idx] : cnt_r[cnt_idx] + COUNT_W'(1);
    idx_w   = IW'(it_r.entry_index);
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_CLASS: begin
        if (head_valid) begin
          state_nxt = BS_APPLY;
        end
      end
      BS_APPLY: begin
        if (out_free) begin
          state_nxt = BS_CLASS;
        end
      end
      default: state_nxt = BS_CLASS;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    apply = 1'b0;
    case (state_r)
      BS_CLASS: pop   = head_valid;
      BS_APPLY: apply = out_free;
      default: begin
        pop   = 1'b0;
        apply = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CLASS;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      it_r      <= head_item;
      found_r   <= found_c;
      cls_r     <= cls_c;
      read_ok_r <= read_ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_matched_r <= 1'b0;
      out_class_r   <= '0;
      out_count_r   <= '0;
      case (it_r.op)
        OP_LOAD: begin
          if (it_r.load_ok) begin
            out_matched_r <= 1'b1;
            out_class_r   <= it_r.class_tag;
          end
        end
        OP_CLASSIFY: begin
          if (found_r) begin
            out_matched_r <= 1'b1;
            out_class_r   <= cls_r;
            if (cnt_any) begin
              out_count_r <= cnt_inc;
            end
          end
        end
        OP_READ: begin
          if (read_ok_r) begin
            out_matched_r <= 1'b1;
            out_class_r   <= id_r[idx_w];
            out_count_r   <= cnt_r[idx_w];
          end
        end
        default: begin
          out_matched_r <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        id_r[i]    <= reset_id(i);
        bound_r[i] <= reset_bound(i);
        cnt_r[i]   <= '0;
      end
    end else if (apply) begin
      case (it_r.op)
        OP_LOAD: begin
          if (it_r.load_ok) begin
            id_r[idx_w]    <= it_r.class_tag;
            bound_r[idx_w] <= it_r.upper_bound;
            cnt_r[idx_w]   <= '0;
          end
        end
        OP_CLASSIFY: begin
          if (found_r && cnt_any) begin
            cnt_r[cnt_idx] <= cnt_inc;
          end
        end
        OP_READ: begin
          if (read_ok_r) begin
            cnt_r[idx_w] <= '0;
          end
        end
        default: begin
          cnt_r[0] <= cnt_r[0];
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_matched   = out_matched_r;
  assign out_class_out = out_class_r;
  assign out_count_out = out_count_r;

endmodule

// File: sv/flow_size_class_counter_core.sv
// Top level of the flow size class counter: config register, front end, queue, back end.
// Depends on fsc_pkg, fsc_front, fsc_queue and fsc_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: op, flow_size,
//   entry_index, class_tag, upper_bound. Ops: load entry, classify flow, read
//   and clear counter. Each transaction yields exactly one result on the
//   output channel (out_valid/out_ready): out_matched, out_class_out,
//   out_count_out.
//   Config: cfg_we with cfg_wdata writes active_classes; write only when idle.
//   An accepted transaction is registered in the queue; the back end then
//   takes one at a time, running the bound search in its class state and
//   the class id search plus counter update in its apply state, and pops
//   no new entry until it has returned to the class state.
//   A 2-entry queue lets the input side keep accepting while the receiver
//   stalls; the held result waits in the output register and the back end
//   pauses, after which in_ready drops once the queue is full.
//   Reset: table returns to its default three classes, counters cleared,
//   active_classes set to 3, queue and output register emptied.
module flow_size_class_counter_core import fsc_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ACT_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [SIZE_W-1:0]  in_flow_size,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [TAG_W-1:0]   in_class_tag,
  input  logic [SIZE_W-1:0]  in_upper_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_matched,
  output logic [TAG_W-1:0]   out_class_out,
  output logic [COUNT_W-1:0] out_count_out
);

  logic [ACT_W-1:0] active_r;
  logic             push_valid;
  logic             push_ready;
  item_t            push_item;
  logic             head_valid;
  item_t            head_item;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  fsc_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_flow_size   (in_flow_size),
    .in_entry_index (in_entry_index),
    .in_class_tag   (in_class_tag),
    .in_upper_bound (in_upper_bound),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  fsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .head_valid (head_valid),
    .pop        (pop),
    .head_item  (head_item)
  );

  fsc_back #(.NUM_CLASSES(NUM_CLASSES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .active_classes (active_r),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_matched    (out_matched),
    .out_class_out  (out_class_out),
    .out_count_out  (out_count_out)
  );

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_class_out == '0 && out_count_out == '0)
    else $error("unmatched result carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("back end pops an empty queue");

  a_no_pop_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !pop |=> out_valid)
    else $error("held result dropped");
`endif

endmodule
